/* rtl/assert_macros.svh */
// Assertion helpers for the clustering block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: lbl");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: lbl");

`endif

/* rtl/kmeans_pkg.sv */
package kmeans_pkg;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_UPDATE   = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CL_DONE,
    ST_UP_DIV,
    ST_UP_EMIT
  } state_e;

  localparam int unsigned CountW = 23;
  localparam int unsigned SumW   = 30;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned MaxFramePixels = 4194304;
  localparam logic [CfgW-1:0] CfgReset = 7'd16;
  localparam logic [0:0] RegClusterCount = 1'b0;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] centroid_index;
    logic [7:0] lightness;
    logic [7:0] chroma_a;
    logic [7:0] chroma_b;
  } pix_in_t;

  typedef struct packed {
    logic [5:0]        label;
    logic [7:0]        out_lightness;
    logic [7:0]        out_chroma_a;
    logic [7:0]        out_chroma_b;
    logic [CountW-1:0] member_count;
    logic              last;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] l;
    logic [7:0] a;
    logic [7:0] b;
  } colour_t;

  // data handed from cell to cell along the row
  typedef struct packed {
    logic        valid;
    colour_t     pix;
    logic [17:0] best_d;
    logic [5:0]  best_idx;
    logic        found;
  } srch_t;

endpackage

/* rtl/kmeans_div.sv */
module kmeans_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [kmeans_pkg::SumW-1:0]   num_i,
  input  logic [kmeans_pkg::CountW-1:0] den_i,
  output logic                       done_o,
  output logic [7:0]                 quo_o
);
  import kmeans_pkg::*;

  // restoring division, 30 steps of one bit over the numerator; quotient known to fit 8 bits
  logic [SumW-1:0]   num_q, num_d;
  logic [CountW:0]   rem_q, rem_d;
  logic [SumW-1:0]   quo_q, quo_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CountW:0]   trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[CountW-1:0], num_q[SumW-1]};
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 5'(SumW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[SumW-2:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[7:0];
endmodule

/* rtl/kmeans_cell.sv */
module kmeans_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       active_i,
  input  logic                       load_i,
  input  kmeans_pkg::colour_t        load_val_i,
  input  logic                       clr_i,
  input  logic                       acc_i,
  input  kmeans_pkg::colour_t        acc_pix_i,
  input  kmeans_pkg::srch_t          srch_i,
  output kmeans_pkg::srch_t          srch_o,
  output kmeans_pkg::colour_t        cent_o,
  output logic [kmeans_pkg::SumW-1:0]   sum_l_o,
  output logic [kmeans_pkg::SumW-1:0]   sum_a_o,
  output logic [kmeans_pkg::SumW-1:0]   sum_b_o,
  output logic [kmeans_pkg::CountW-1:0] cnt_o
);
  import kmeans_pkg::*;

  localparam logic [5:0] IdxC = 6'(Index);

  colour_t           cent_q;
  logic [SumW-1:0]   sl_q, sa_q, sb_q;
  logic [CountW-1:0] cnt_q;
  srch_t             srch_q, srch_d;
  logic [7:0]        dl, da, db;
  logic [17:0]       sq_dist;

  always_comb begin
    dl = (cent_q.l > srch_i.pix.l) ? cent_q.l - srch_i.pix.l : srch_i.pix.l - cent_q.l;
    da = (cent_q.a > srch_i.pix.a) ? cent_q.a - srch_i.pix.a : srch_i.pix.a - cent_q.a;
    db = (cent_q.b > srch_i.pix.b) ? cent_q.b - srch_i.pix.b : srch_i.pix.b - cent_q.b;
    sq_dist = 18'(16'(dl * dl)) + 18'(16'(da * da)) + 18'(16'(db * db));
    srch_d = srch_i;
    if (srch_i.valid && active_i && (!srch_i.found || sq_dist < srch_i.best_d)) begin
      srch_d.best_d   = sq_dist;
      srch_d.best_idx = IdxC;
      srch_d.found    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cent_q <= '0;
      sl_q   <= '0;
      sa_q   <= '0;
      sb_q   <= '0;
      cnt_q  <= '0;
      srch_q <= '0;
    end else begin
      srch_q <= srch_d;
      if (load_i) cent_q <= load_val_i;
      if (clr_i) begin
        sl_q  <= '0;
        sa_q  <= '0;
        sb_q  <= '0;
        cnt_q <= '0;
      end else if (acc_i) begin
        sl_q  <= sl_q + SumW'(acc_pix_i.l);
        sa_q  <= sa_q + SumW'(acc_pix_i.a);
        sb_q  <= sb_q + SumW'(acc_pix_i.b);
        cnt_q <= cnt_q + CountW'(1);
      end
    end
  end

  assign srch_o  = srch_q;
  assign cent_o  = cent_q;
  assign sum_l_o = sl_q;
  assign sum_a_o = sa_q;
  assign sum_b_o = sb_q;
  assign cnt_o   = cnt_q;
endmodule

/* rtl/kmeans_pixel_cluster_pass_unit.sv */
// K-means pass unit. Load (op 0) writes a centroid and gives no result.
// Classify (op 1) walks the pixel down a row of MAX_CLUSTERS distance cells,
// one cell a cycle, and gives one result. Update (op 2) divides each active
// cluster's three sums by its count with one shared bit-serial divider; an
// empty cluster skips the divider. Update gives one result per active cluster.
// Results appear on result_valid_o for a single cycle each and cannot be
// stalled; busy is high while working.
module kmeans_pixel_cluster_pass_unit #(
  parameter int unsigned MAX_CLUSTERS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  kmeans_pkg::pix_in_t  item_i,
  output logic                 result_valid_o,
  output kmeans_pkg::pix_out_t result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import kmeans_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned IdxW = $clog2(MAX_CLUSTERS);
  localparam logic [CountW-1:0] FullCnt = CountW'(MaxFramePixels);

  logic [CfgW-1:0] cfg_q;
  logic            cfg_wr;
  logic [6:0]      nact;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegClusterCount);
  assign prdata = (paddr[2] == RegClusterCount) ? 32'(cfg_q) : '0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= CfgReset;
    else if (cfg_wr) cfg_q <= pwdata[CfgW-1:0];
  end
  always_comb begin
    nact = cfg_q;
    if (nact == '0) nact = 7'd1;
    if (nact > 7'(MAX_CLUSTERS)) nact = 7'(MAX_CLUSTERS);
  end

  state_e state_q, state_d;
  colour_t pix_q, pix_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [1:0] ch_q, ch_d;
  logic [7:0] ql_q, qa_q, ql_d, qa_d;
  logic [IdxW-1:0] best_q, best_d;

  srch_t   chain [MAX_CLUSTERS+1];
  colour_t cent  [MAX_CLUSTERS];
  logic [SumW-1:0]   sl [MAX_CLUSTERS];
  logic [SumW-1:0]   sa [MAX_CLUSTERS];
  logic [SumW-1:0]   sb [MAX_CLUSTERS];
  logic [CountW-1:0] cn [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] ld, acc;
  logic clr_all;
  colour_t ld_val;

  logic accept;
  assign accept = start && !busy;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = accept && (item_i.operation == OP_CLASSIFY);
    chain[0].pix   = {item_i.lightness, item_i.chroma_a, item_i.chroma_b};
  end

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    kmeans_cell #(.Index(g)) u_cell (
      .clk_i, .rst_ni,
      .active_i  (7'(g) < nact),
      .load_i    (ld[g]),
      .load_val_i(ld_val),
      .clr_i     (clr_all),
      .acc_i     (acc[g]),
      .acc_pix_i (pix_q),
      .srch_i    (chain[g]),
      .srch_o    (chain[g+1]),
      .cent_o    (cent[g]),
      .sum_l_o   (sl[g]),
      .sum_a_o   (sa[g]),
      .sum_b_o   (sb[g]),
      .cnt_o     (cn[g])
    );
  end

  // divider is kicked in the same cycle that idx_q and ch_q first name the sum to divide
  logic kick_q;
  logic div_done;
  logic [SumW-1:0] div_num;
  logic [7:0] div_q;
  kmeans_div u_div (
    .clk_i, .rst_ni,
    .start_i(kick_q), .num_i(div_num), .den_i(cn[idx_q]),
    .done_o(div_done), .quo_o(div_q)
  );

  always_comb begin
    case (ch_q)
      2'd0:    div_num = sl[idx_q];
      2'd1:    div_num = sa[idx_q];
      default: div_num = sb[idx_q];
    endcase
  end

  pix_out_t res_d, res_q;
  logic     rv_d, rv_q;

  always_comb begin
    state_d   = state_q;
    pix_d     = pix_q;
    idx_d     = idx_q;
    ch_d      = ch_q;
    ql_d      = ql_q;
    qa_d      = qa_q;
    best_d    = best_q;
    ld        = '0;
    acc       = '0;
    ld_val    = {item_i.lightness, item_i.chroma_a, item_i.chroma_b};
    clr_all   = 1'b0;
    rv_d      = 1'b0;
    res_d     = res_q;
    busy      = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pix_d = {item_i.lightness, item_i.chroma_a, item_i.chroma_b};
          case (item_i.operation)
            OP_LOAD: begin
              if (32'(item_i.centroid_index) < MAX_CLUSTERS)
                ld[IdxW'(item_i.centroid_index)] = 1'b1;
            end
            OP_CLASSIFY: state_d = ST_SCAN;
            OP_UPDATE: begin
              idx_d     = '0;
              ch_d      = 2'd0;
              state_d   = (cn[0] != '0) ? ST_UP_DIV : ST_UP_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (chain[MAX_CLUSTERS].valid) begin
          best_d  = IdxW'(chain[MAX_CLUSTERS].best_idx);
          state_d = ST_CL_DONE;
        end
      end
      ST_CL_DONE: begin
        if (cn[best_q] < FullCnt) acc[best_q] = 1'b1;
        rv_d  = 1'b1;
        res_d = {6'(best_q), cent[best_q], CountW'(0), 1'b1};
        state_d = ST_IDLE;
      end
      ST_UP_DIV: begin
        if (div_done) begin
          case (ch_q)
            2'd0: begin
              ql_d = div_q;
              ch_d = 2'd1;
            end
            2'd1: begin
              qa_d = div_q;
              ch_d = 2'd2;
            end
            default: begin
              ld[idx_q] = 1'b1;
              ld_val    = {ql_q, qa_q, div_q};
              state_d   = ST_UP_EMIT;
            end
          endcase
        end
      end
      ST_UP_EMIT: begin
        rv_d  = 1'b1;
        res_d = {6'(idx_q), cent[idx_q], cn[idx_q], 1'b0};
        if (7'(idx_q) + 7'd1 == nact) begin
          res_d.last = 1'b1;
          clr_all    = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          idx_d = idx_q + IdxW'(1);
          ch_d  = 2'd0;
          if (cn[idx_d] != '0) begin
            state_d = ST_UP_DIV;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) kick_q <= 1'b0;
    else kick_q <= (state_d == ST_UP_DIV) && ((state_q != ST_UP_DIV) || div_done);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      ch_q    <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ch_q    <= ch_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    ql_q   <= ql_d;
    qa_q   <= qa_d;
    best_q <= best_d;
    res_q  <= res_d;
  end

  assign result_valid_o = rv_q;
  assign result_o       = res_q;

  `ASSERT_IMPL(a_res_busy, rv_d, state_q != ST_IDLE)
  `ASSERT_IMPL(a_no_div_idle, div_done, state_q == ST_UP_DIV)
  `ASSERT_NEXT(a_scan_exit, state_q == ST_CL_DONE, state_q == ST_IDLE && rv_q)
  `ASSERT_IMPL(a_one_acc, state_q == ST_CL_DONE, $onehot0(acc))
  `ASSERT_IMPL(a_kick_div, kick_q, state_q == ST_UP_DIV)
endmodule

/* tb/tb_kmeans_pixel_cluster_pass_unit.sv */
`timescale 1ns / 100ps

module tb_kmeans_pixel_cluster_pass_unit;
  import kmeans_pkg::*;

  localparam int unsigned NClust    = 16;
  localparam int unsigned FramePix  = MaxFramePixels;
  localparam int unsigned IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  pix_in_t     item_i = '0;
  logic        result_valid_o;
  pix_out_t    result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  kmeans_pixel_cluster_pass_unit #(
    .MAX_CLUSTERS(NClust)
  ) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [6:0]        count_reg;
  colour_t           centroids [NClust];
  logic [SumW-1:0]   acc_l [NClust];
  logic [SumW-1:0]   acc_a [NClust];
  logic [SumW-1:0]   acc_b [NClust];
  logic [CountW-1:0] members [NClust];
  pix_out_t          expected_words [$];
  int                errors = 0;
  int                idle_cycles = 0;
  int                send_idle_pct = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int unsigned active_count();
    if (count_reg == 0) return 1;
    if (count_reg > NClust) return NClust;
    return count_reg;
  endfunction

  function automatic int unsigned sqd(input logic [7:0] x, input logic [7:0] y);
    int unsigned d;
    d = (x > y) ? x - y : y - x;
    return d * d;
  endfunction

  task automatic predict_word(input pix_in_t w);
    int unsigned n, best, best_d, d, m;
    pix_out_t r;
    n = active_count();
    case (w.operation)
      OP_LOAD: begin
        if (w.centroid_index < NClust)
          centroids[w.centroid_index[3:0]] = '{w.lightness, w.chroma_a, w.chroma_b};
      end
      OP_CLASSIFY: begin
        best = 0;
        best_d = 32'hFFFF_FFFF;
        for (int i = 0; i < n; i++) begin
          d = sqd(centroids[i].l, w.lightness) + sqd(centroids[i].a, w.chroma_a)
              + sqd(centroids[i].b, w.chroma_b);
          if (d < best_d) begin
            best_d = d;
            best = i;
          end
        end
        if (members[best] < FramePix) begin
          acc_l[best] += w.lightness;
          acc_a[best] += w.chroma_a;
          acc_b[best] += w.chroma_b;
          members[best] += 1;
        end
        r = '0;
        r.label = 6'(best);
        {r.out_lightness, r.out_chroma_a, r.out_chroma_b} = centroids[best];
        r.last = 1'b1;
        expected_words = {expected_words, r};
      end
      OP_UPDATE: begin
        for (int i = 0; i < n; i++) begin
          m = members[i];
          if (m != 0) begin
            centroids[i].l = 8'(acc_l[i] / m);
            centroids[i].a = 8'(acc_a[i] / m);
            centroids[i].b = 8'(acc_b[i] / m);
          end
          r = '0;
          r.label = 6'(i);
          {r.out_lightness, r.out_chroma_a, r.out_chroma_b} = centroids[i];
          r.member_count = CountW'(m);
          r.last = (i + 1 == n);
          expected_words = {expected_words, r};
        end
        for (int i = 0; i < NClust; i++) begin
          acc_l[i] = '0;
          acc_a[i] = '0;
          acc_b[i] = '0;
          members[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    pix_out_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        e = expected_words.pop_front();
        if (result_o.label !== e.label)
          report_mismatch($sformatf("label %0d, want %0d", result_o.label, e.label));
        if (result_o.out_lightness !== e.out_lightness)
          report_mismatch($sformatf("L %0d, want %0d", result_o.out_lightness,
                                    e.out_lightness));
        if (result_o.out_chroma_a !== e.out_chroma_a)
          report_mismatch($sformatf("a %0d, want %0d", result_o.out_chroma_a,
                                    e.out_chroma_a));
        if (result_o.out_chroma_b !== e.out_chroma_b)
          report_mismatch($sformatf("b %0d, want %0d", result_o.out_chroma_b,
                                    e.out_chroma_b));
        if (result_o.member_count !== e.member_count)
          report_mismatch($sformatf("count %0d, want %0d", result_o.member_count,
                                    e.member_count));
        if (result_o.last !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", result_o.last, e.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // start stays high after the accepting edge until the next word or drain
  task automatic send_word(input pix_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4 * NClust * 110) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [31:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {RegClusterCount, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    count_reg = v[6:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic pix_in_t mk(input op_e op, input int idx, input int l,
                                 input int a, input int b);
    pix_in_t w;
    w.operation = op;
    w.centroid_index = 6'(idx);
    w.lightness = 8'(l);
    w.chroma_a = 8'(a);
    w.chroma_b = 8'(b);
    return w;
  endfunction

  function automatic pix_in_t rand_word();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 20) return mk(OP_LOAD, $urandom_range(p < 2 ? 63 : 15), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255));
    if (p < 96) return mk(OP_CLASSIFY, $urandom_range(63), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255));
    if (p < 98) return mk(OP_UPDATE, $urandom_range(63), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255));
    return mk(OP_NONE, $urandom_range(63), $urandom_range(255), $urandom_range(255),
              $urandom_range(255));
  endfunction

  pix_in_t directed [] = '{
    mk(OP_CLASSIFY, 0, 255, 255, 255),
    mk(OP_UPDATE, 0, 0, 0, 0),
    mk(OP_LOAD, 0, 255, 0, 255),
    mk(OP_LOAD, 1, 0, 255, 0),
    mk(OP_LOAD, 15, 128, 128, 128),
    mk(OP_LOAD, 63, 17, 17, 17),
    mk(OP_LOAD, 20, 1, 2, 3),
    mk(OP_CLASSIFY, 63, 255, 0, 255),
    mk(OP_CLASSIFY, 0, 0, 255, 0),
    mk(OP_CLASSIFY, 0, 130, 120, 140),
    mk(OP_CLASSIFY, 0, 0, 0, 0),
    mk(OP_CLASSIFY, 0, 254, 1, 253),
    mk(OP_NONE, 42, 170, 85, 170),
    mk(OP_UPDATE, 63, 255, 255, 255),
    mk(OP_UPDATE, 0, 0, 0, 0),
    mk(OP_LOAD, 2, 10, 10, 10),
    mk(OP_LOAD, 3, 10, 10, 10),
    mk(OP_CLASSIFY, 5, 10, 10, 10),
    mk(OP_UPDATE, 0, 0, 0, 0)
  };

  initial begin
    count_reg = CfgReset;
    for (int i = 0; i < NClust; i++) begin
      centroids[i] = '0;
      acc_l[i] = '0;
      acc_a[i] = '0;
      acc_b[i] = '0;
      members[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, extremes, ties, ignored ops
    foreach (directed[k]) send_word(directed[k]);
    write_count(1);
    send_word(mk(OP_CLASSIFY, 0, 99, 99, 99));
    send_word(mk(OP_UPDATE, 0, 0, 0, 0));
    write_count(0);
    send_word(mk(OP_CLASSIFY, 0, 1, 1, 1));
    send_word(mk(OP_UPDATE, 0, 0, 0, 0));
    write_count(127);
    send_word(mk(OP_UPDATE, 0, 0, 0, 0));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: send_idle_pct = 18;
        1: send_idle_pct = 87;
        default: send_idle_pct = 0;
      endcase
      case (ph)
        0: write_count(16);
        1: write_count(2);
        2: write_count($urandom_range(1, 16));
        3: write_count(64);
        4: write_count($urandom_range(17, 127));
        default: write_count($urandom_range(0, 16));
      endcase
      repeat (85) send_word(rand_word());
      send_word(mk(OP_UPDATE, 0, 0, 0, 0));
    end

    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
